FILE: hdl/fncl_pkg.sv
// fncl_pkg: shared types, constants and helpers for the fat next-cluster lookup
// used by the channel interfaces, the controller, the datapath and the top level
// no dependencies

package fncl_pkg;

  localparam int MAX_SECTOR_BYTES = 4096;
  localparam int CACHE_BYTES      = 2 * MAX_SECTOR_BYTES;
  localparam int CACHE_AW         = $clog2(CACHE_BYTES);
  localparam int SH_MIN           = 9;
  localparam int SH_MAX           = $clog2(MAX_SECTOR_BYTES);

  localparam int CLUS_W    = 32;
  localparam int TAG_W     = 32;
  localparam int SECTOR_W  = 48;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 48;

  localparam logic [TAG_W-1:0] TAG_NONE = '1;

  // fat types
  localparam logic [1:0] FAT12 = 2'd0;
  localparam logic [1:0] FAT16 = 2'd1;
  localparam logic [1:0] FAT32 = 2'd2;
  localparam logic [1:0] EXFAT = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FAT_TYPE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_LG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAT_BASE   = 2'd2;

  localparam logic [31:0] MARK_FAT12 = 32'h0000_0FF8;
  localparam logic [31:0] MARK_FAT16 = 32'h0000_FFF8;
  localparam logic [31:0] MARK_FAT32 = 32'h0FFF_FFF8;
  localparam logic [31:0] MARK_EXFAT = 32'hFFFF_FFF7;
  localparam logic [11:0] MASK12     = 12'hFFF;
  localparam logic [31:0] MASK28     = 32'h0FFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_CMP,
    ST_RD,
    ST_DRAIN,
    ST_DONE
  } fncl_state_t;

  typedef struct packed {
    logic       in_ready;
    logic       calc;
    logic       cmp;
    logic       rd_en;
    logic [1:0] rd_idx;
    logic       out_load;
  } fncl_cmd_t;

  typedef struct packed {
    logic lookup_acc;
    logic hit;
    logic wide;
    logic out_free;
  } fncl_sts_t;

  // sector size log2 held to the supported range
  function automatic logic [3:0] eff_shift(input logic [3:0] lg2);
    logic [3:0] sh;
    sh = lg2;
    if (sh < 4'(SH_MIN)) sh = 4'(SH_MIN);
    if (sh > 4'(SH_MAX)) sh = 4'(SH_MAX);
    return sh;
  endfunction

endpackage

FILE: hdl/fncl_in_if.sv
// fncl_in_if: input channel, lookup and fill beats
// depends on fncl_pkg

interface fncl_in_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic [fncl_pkg::CLUS_W-1:0]       cluster;
  logic [fncl_pkg::TAG_W-1:0]        fill_sector;
  logic [fncl_pkg::CACHE_AW-1:0]     fill_offset;
  logic [7:0]                        fill_byte;
  logic                              fill_last;

  modport source (
    output valid, mode, cluster, fill_sector, fill_offset, fill_byte, fill_last,
    input  ready
  );
  modport sink (
    input  valid, mode, cluster, fill_sector, fill_offset, fill_byte, fill_last,
    output ready
  );
endinterface

FILE: hdl/fncl_out_if.sv
// fncl_out_if: result channel, one beat per lookup
// depends on fncl_pkg

interface fncl_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [fncl_pkg::SECTOR_W-1:0] read_sector;
  logic [1:0]                    read_count;
  logic [fncl_pkg::CLUS_W-1:0]   next_cluster;
  logic                          end_of_chain;

  modport source (
    output valid, hit, read_sector, read_count, next_cluster, end_of_chain,
    input  ready
  );
  modport sink (
    input  valid, hit, read_sector, read_count, next_cluster, end_of_chain,
    output ready
  );
endinterface

FILE: hdl/fncl_cfg_if.sv
// fncl_cfg_if: configuration write channel, register index and data
// depends on fncl_pkg

interface fncl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fncl_pkg::CFG_IDX_W-1:0] index;
  logic [fncl_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/fncl_ctrl.sv
// fncl_ctrl: lookup sequencer, drives the datapath through fncl_cmd_t
// depends on fncl_pkg

module fncl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  fncl_pkg::fncl_sts_t sts,
  output fncl_pkg::fncl_cmd_t cmd
);

  fncl_pkg::fncl_state_t state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [1:0] last_idx;

  assign last_idx = sts.wide ? 2'd3 : 2'd1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fncl_pkg::ST_IDLE: begin
        if (sts.lookup_acc) state_nxt = fncl_pkg::ST_CALC;
      end
      fncl_pkg::ST_CALC: state_nxt = fncl_pkg::ST_CMP;
      fncl_pkg::ST_CMP: begin
        state_nxt = sts.hit ? fncl_pkg::ST_RD : fncl_pkg::ST_DONE;
      end
      fncl_pkg::ST_RD: begin
        if (idx_r == last_idx) state_nxt = fncl_pkg::ST_DRAIN;
      end
      fncl_pkg::ST_DRAIN: state_nxt = fncl_pkg::ST_DONE;
      fncl_pkg::ST_DONE: begin
        if (sts.out_free) state_nxt = fncl_pkg::ST_IDLE;
      end
      default: state_nxt = fncl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (state_r == fncl_pkg::ST_CMP) idx_nxt = 2'd0;
    else if (state_r == fncl_pkg::ST_RD) idx_nxt = idx_r + 2'd1;
  end

  always_comb begin
    cmd          = '0;
    cmd.rd_idx   = idx_r;
    case (state_r)
      fncl_pkg::ST_IDLE:  cmd.in_ready = 1'b1;
      fncl_pkg::ST_CALC:  cmd.calc     = 1'b1;
      fncl_pkg::ST_CMP:   cmd.cmp      = 1'b1;
      fncl_pkg::ST_RD:    cmd.rd_en    = 1'b1;
      fncl_pkg::ST_DRAIN: cmd.rd_en    = 1'b0;
      fncl_pkg::ST_DONE:  cmd.out_load = sts.out_free;
      default:            cmd          = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fncl_pkg::ST_IDLE;
      idx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // no more byte reads than the entry holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fncl_pkg::ST_RD) |-> (idx_r <= last_idx))
    else $error("fncl_ctrl: read index past entry");

  // a miss goes straight to the result
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fncl_pkg::ST_CMP && !sts.hit) |=> (state_r == fncl_pkg::ST_DONE))
    else $error("fncl_ctrl: miss did not go to result");

  // the last byte read is always drained before the result
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && $past(state_r) == fncl_pkg::ST_DRAIN) |-> $past(sts.hit, 2) == 1'b0
      || $past(state_r, 2) == fncl_pkg::ST_RD || $past(state_r, 2) == fncl_pkg::ST_DRAIN)
    else $error("fncl_ctrl: result without drained read");

endmodule

FILE: hdl/fncl_dp.sv
// fncl_dp: config registers, cache tag, sector cache memory, entry decode
// and the result register; depends on fncl_pkg and the channel interfaces

module fncl_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  fncl_pkg::fncl_cmd_t cmd,
  output fncl_pkg::fncl_sts_t sts,
  fncl_in_if.sink             in_if,
  fncl_out_if.source          out_if,
  fncl_cfg_if.sink            cfg_if
);

  localparam int AW = fncl_pkg::CACHE_AW;

  logic [1:0]                    fat_type_r;
  logic [3:0]                    sec_lg2_r;
  logic [fncl_pkg::SECTOR_W-1:0] base_r;
  logic [fncl_pkg::TAG_W-1:0]    tag_r, tag_nxt;

  logic [fncl_pkg::CLUS_W-1:0]   clus_r;
  logic [fncl_pkg::TAG_W-1:0]    fpos_r;
  logic [AW-1:0]                 boff_r;
  logic [fncl_pkg::SECTOR_W-1:0] rsec_r;
  logic                          hit_r;
  logic [31:0]                   word_r;
  logic                          rvalid_r;
  logic [1:0]                    ridx_r;
  logic [7:0]                    rdata_r;
  logic [7:0]                    mem [fncl_pkg::CACHE_BYTES];

  logic                          out_valid_r;
  logic                          out_hit_r;
  logic [fncl_pkg::SECTOR_W-1:0] out_sector_r;
  logic [1:0]                    out_count_r;
  logic [31:0]                   out_next_r;
  logic                          out_eoc_r;

  logic          in_acc, fill_acc, cfg_acc;
  logic [3:0]    sh, shamt;
  logic [1:0]    esh;
  logic [33:0]   triple;
  logic [32:0]   eidx;
  logic [AW-1:0] bmask;
  logic [AW-1:0] raddr;
  logic          hit_now;
  logic [31:0]   val;
  logic [31:0]   mark;
  logic [15:0]   w12;
  logic          eoc;

  assign in_if.ready  = cmd.in_ready;
  assign cfg_if.ready = 1'b1;
  assign in_acc   = in_if.valid && cmd.in_ready;
  assign fill_acc = in_acc && in_if.mode;
  assign cfg_acc  = cfg_if.valid;

  // config and tag
  always_comb begin
    tag_nxt = tag_r;
    if (fill_acc && in_if.fill_last) tag_nxt = in_if.fill_sector;
    if (cfg_acc && (cfg_if.index == fncl_pkg::REG_FAT_TYPE ||
                    cfg_if.index == fncl_pkg::REG_SECTOR_LG2)) begin
      tag_nxt = fncl_pkg::TAG_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fat_type_r <= fncl_pkg::FAT12;
      sec_lg2_r  <= 4'(fncl_pkg::SH_MIN);
      base_r     <= '0;
      tag_r      <= fncl_pkg::TAG_NONE;
    end else begin
      tag_r <= tag_nxt;
      if (cfg_acc) begin
        case (cfg_if.index)
          fncl_pkg::REG_FAT_TYPE:   fat_type_r <= cfg_if.data[1:0];
          fncl_pkg::REG_SECTOR_LG2: sec_lg2_r  <= cfg_if.data[3:0];
          fncl_pkg::REG_FAT_BASE:   base_r     <= cfg_if.data[fncl_pkg::SECTOR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // sector index and byte offset of the entry
  assign sh     = fncl_pkg::eff_shift(sec_lg2_r);
  assign esh    = (fat_type_r == fncl_pkg::FAT12) ? 2'd0 :
                  (fat_type_r == fncl_pkg::FAT16) ? 2'd1 : 2'd2;
  assign shamt  = sh - 4'(esh);
  assign triple = {2'b0, clus_r} + {1'b0, clus_r, 1'b0};
  assign eidx   = (fat_type_r == fncl_pkg::FAT12) ? triple[33:1] : {1'b0, clus_r};
  assign bmask  = AW'((14'd1 << shamt) - 14'd1);

  always_ff @(posedge clk) begin
    if (in_acc && !in_if.mode) clus_r <= in_if.cluster;
    if (cmd.calc) begin
      fpos_r <= 32'(eidx >> shamt);
      boff_r <= AW'((eidx[AW-1:0] & bmask) << esh);
    end
    if (cmd.cmp) begin
      hit_r  <= hit_now;
      rsec_r <= base_r + fncl_pkg::SECTOR_W'(fpos_r);
    end
  end

  assign hit_now = (fpos_r == tag_r);

  // sector cache, one write and one registered read
  assign raddr = boff_r + AW'(cmd.rd_idx);

  always_ff @(posedge clk) begin
    if (fill_acc) mem[in_if.fill_offset] <= in_if.fill_byte;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvalid_r <= 1'b0;
    end else begin
      rvalid_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    ridx_r <= cmd.rd_idx;
    if (cmd.cmp) word_r <= '0;
    else if (rvalid_r) word_r[8*ridx_r +: 8] <= rdata_r;
  end

  // entry decode
  assign w12 = clus_r[0] ? {4'b0, word_r[15:4]} : word_r[15:0];

  always_comb begin
    case (fat_type_r)
      fncl_pkg::FAT12: begin
        val  = {20'b0, w12[11:0] & fncl_pkg::MASK12};
        mark = fncl_pkg::MARK_FAT12;
      end
      fncl_pkg::FAT16: begin
        val  = {16'b0, word_r[15:0]};
        mark = fncl_pkg::MARK_FAT16;
      end
      fncl_pkg::FAT32: begin
        val  = word_r & fncl_pkg::MASK28;
        mark = fncl_pkg::MARK_FAT32;
      end
      default: begin
        val  = word_r;
        mark = fncl_pkg::MARK_EXFAT;
      end
    endcase
  end

  assign eoc = (val == 32'd0) || (val >= mark);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hit_r    <= hit_r;
      out_sector_r <= hit_r ? '0 : rsec_r;
      out_count_r  <= hit_r ? 2'd0 : ((fat_type_r == fncl_pkg::FAT12) ? 2'd2 : 2'd1);
      out_next_r   <= hit_r ? val : 32'd0;
      out_eoc_r    <= hit_r ? eoc : 1'b0;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.hit          = out_hit_r;
  assign out_if.read_sector  = out_sector_r;
  assign out_if.read_count   = out_count_r;
  assign out_if.next_cluster = out_next_r;
  assign out_if.end_of_chain = out_eoc_r;

  assign sts.lookup_acc = in_acc && !in_if.mode;
  assign sts.hit        = hit_now;
  assign sts.wide       = fat_type_r[1];
  assign sts.out_free   = !out_valid_r || out_if.ready;

  // a result is never loaded over one still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_if.ready))
    else $error("fncl_dp: result overwritten");

  // a fat type change drops the cached sector
  assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_if.valid && cfg_if.index == fncl_pkg::REG_FAT_TYPE) |=> (tag_r == fncl_pkg::TAG_NONE))
    else $error("fncl_dp: tag kept after fat type write");

  // cache reads and fill writes never share a cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> !fill_acc)
    else $error("fncl_dp: read during fill");

  // read data is captured only after an issued read
  assert property (@(posedge clk) disable iff (!rst_n)
    rvalid_r |-> $past(cmd.rd_en))
    else $error("fncl_dp: stray read capture");

endmodule

FILE: hdl/fat_next_cluster_lookup_top.sv
// Fat next-cluster lookup with a one-sector FAT cache (two sectors for FAT12).
// Fill beats are taken one per cycle when idle and write the cache at once; the
// fill beat with fill_last set commits the cache tag. A lookup holds the
// input in its calc, compare and result states; a hit reads its entry bytes (two
// for FAT12/FAT16, four for FAT32/exFAT) via the cache's single read port, one
// byte per cycle. The result sits in an output register, so the next beat is
// taken while it waits. Writing fat_type or sector_size_log2 drops the cached
// sector. Unfilled cache bytes read back as undefined.
// depends on fncl_pkg, the channel interfaces, fncl_ctrl and fncl_dp

module fat_next_cluster_lookup_top (
  input  logic       clk,
  input  logic       rst_n,
  fncl_in_if.sink    in_if,
  fncl_out_if.source out_if,
  fncl_cfg_if.sink   cfg_if
);

  fncl_pkg::fncl_cmd_t cmd;
  fncl_pkg::fncl_sts_t sts;

  fncl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  fncl_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

endmodule

FILE: verif/fat_next_cluster_lookup_top_tb.sv
// fat_next_cluster_lookup_top_tb: self-checking bench for the fat next-cluster lookup
// streams lookup and fill beats in random bursts against a stalling receiver and checks
// each answer against its own cache image and tag; needs fncl_pkg and the channel interfaces

module fat_next_cluster_lookup_top_tb;

  localparam logic                           MODE_LOOKUP   = 1'b0;
  localparam logic                           MODE_FILL     = 1'b1;
  localparam logic [fncl_pkg::CFG_IDX_W-1:0] REG_SPARE     = 2'd3;
  localparam int                             IDLE_LIMIT    = 1000;
  localparam int                             SETTLE_CYCLES = 16;
  localparam int                             PHASES        = 20;
  localparam int                             PHASE_BEATS   = 100;

  typedef struct packed {
    logic                          mode;
    logic [fncl_pkg::CLUS_W-1:0]   cluster;
    logic [fncl_pkg::TAG_W-1:0]    fill_sector;
    logic [fncl_pkg::CACHE_AW-1:0] fill_offset;
    logic [7:0]                    fill_byte;
    logic                          fill_last;
  } host_beat_t;

  typedef struct packed {
    logic                          hit;
    logic [fncl_pkg::SECTOR_W-1:0] read_sector;
    logic [1:0]                    read_count;
    logic [fncl_pkg::CLUS_W-1:0]   next_cluster;
    logic                          end_of_chain;
  } fat_answer_t;

  logic clk;
  logic rst_n;

  fncl_in_if  in_ch ();
  fncl_out_if out_ch ();
  fncl_cfg_if cfg_ch ();

  fat_next_cluster_lookup_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  logic [7:0]                    cache_img [fncl_pkg::CACHE_BYTES];
  logic [fncl_pkg::TAG_W-1:0]    tag_img;
  logic [1:0]                    cur_type;
  logic [3:0]                    cur_lg2;
  logic [fncl_pkg::SECTOR_W-1:0] cur_base;

  bit                            q_written [fncl_pkg::CACHE_BYTES];
  logic [fncl_pkg::TAG_W-1:0]    q_tag;

  host_beat_t  host_beats [$];
  fat_answer_t due_answers [$];
  int          mismatches;
  int          idle_cycles;
  int          beats_queued;
  bit          in_taken;
  int          burst_left;
  int          gap_left;
  logic [15:0] ready_pat;
  int          pat_age;
  int          pat_pos;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned sector_shift();
    if (cur_lg2 < 4'(fncl_pkg::SH_MIN)) return fncl_pkg::SH_MIN;
    if (cur_lg2 > 4'(fncl_pkg::SH_MAX)) return fncl_pkg::SH_MAX;
    return cur_lg2;
  endfunction

  // fat-relative sector and byte offset of a cluster's entry
  function automatic void locate(input logic [fncl_pkg::CLUS_W-1:0] clus,
                                 output logic [63:0] fpos, output logic [63:0] boff);
    int unsigned sh;
    int unsigned esh;
    logic [63:0] off;
    logic [63:0] ssize;
    sh    = sector_shift();
    ssize = 64'd1 << sh;
    if (cur_type == fncl_pkg::FAT12) begin
      off  = (64'(clus) * 3) >> 1;
      fpos = off >> sh;
      boff = off & (ssize - 1);
    end else begin
      esh  = (cur_type == fncl_pkg::FAT16) ? 1 : 2;
      fpos = 64'(clus) >> (sh - esh);
      boff = (64'(clus) & ((ssize >> esh) - 1)) << esh;
    end
  endfunction

  function automatic logic [31:0] end_mark();
    case (cur_type)
      fncl_pkg::FAT12: return fncl_pkg::MARK_FAT12;
      fncl_pkg::FAT16: return fncl_pkg::MARK_FAT16;
      fncl_pkg::FAT32: return fncl_pkg::MARK_FAT32;
      default:         return fncl_pkg::MARK_EXFAT;
    endcase
  endfunction

  function automatic fat_answer_t answer_lookup(input logic [fncl_pkg::CLUS_W-1:0] clus);
    fat_answer_t a;
    logic [63:0] fpos;
    logic [63:0] boff;
    logic [15:0] w;
    logic [31:0] val;
    a = '0;
    locate(clus, fpos, boff);
    if (fpos != 64'(tag_img)) begin
      a.read_sector = fncl_pkg::SECTOR_W'(64'(cur_base) + fpos);
      a.read_count  = (cur_type == fncl_pkg::FAT12) ? 2'd2 : 2'd1;
      return a;
    end
    w = {cache_img[fncl_pkg::CACHE_AW'(boff + 1)], cache_img[fncl_pkg::CACHE_AW'(boff)]};
    case (cur_type)
      fncl_pkg::FAT12: val = 32'((clus[0] ? (w >> 4) : w) & 16'h0FFF);
      fncl_pkg::FAT16: val = 32'(w);
      fncl_pkg::FAT32: val = {4'h0, cache_img[fncl_pkg::CACHE_AW'(boff + 3)][3:0],
                              cache_img[fncl_pkg::CACHE_AW'(boff + 2)], w};
      default:         val = {cache_img[fncl_pkg::CACHE_AW'(boff + 3)],
                              cache_img[fncl_pkg::CACHE_AW'(boff + 2)], w};
    endcase
    a.hit          = 1'b1;
    a.next_cluster = val;
    a.end_of_chain = (val == 32'd0) || (val >= end_mark());
    return a;
  endfunction

  function automatic logic [fncl_pkg::CFG_DAT_W-1:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic host_beat_t junk_beat();
    host_beat_t b;
    b.mode        = MODE_LOOKUP;
    b.cluster     = $urandom;
    b.fill_sector = $urandom;
    b.fill_offset = fncl_pkg::CACHE_AW'($urandom);
    b.fill_byte   = 8'($urandom);
    b.fill_last   = 1'($urandom);
    return b;
  endfunction

  task automatic push_fill(input logic [fncl_pkg::CACHE_AW-1:0] offset, input logic [7:0] data,
                           input logic last, input logic [fncl_pkg::TAG_W-1:0] sector);
    host_beat_t b;
    b             = junk_beat();
    b.mode        = MODE_FILL;
    b.fill_offset = offset;
    b.fill_byte   = data;
    b.fill_last   = last;
    b.fill_sector = sector;
    host_beats.push_back(b);
    beats_queued++;
    q_written[offset] = 1'b1;
    if (last) q_tag = sector;
  endtask

  task automatic push_lookup(input logic [fncl_pkg::CLUS_W-1:0] clus);
    host_beat_t  b;
    logic [63:0] fpos;
    logic [63:0] boff;
    int          nbytes;
    locate(clus, fpos, boff);
    nbytes = (cur_type == fncl_pkg::FAT12 || cur_type == fncl_pkg::FAT16) ? 2 : 4;
    // entry bytes of a hit are filled first when still unwritten
    if (fpos == 64'(q_tag)) begin
      for (int i = 0; i < nbytes; i++) begin
        if (!q_written[fncl_pkg::CACHE_AW'(boff + 64'(i))])
          push_fill(fncl_pkg::CACHE_AW'(boff + 64'(i)), 8'($urandom), 1'b0, $urandom);
      end
    end
    b         = junk_beat();
    b.mode    = MODE_LOOKUP;
    b.cluster = clus;
    host_beats.push_back(b);
    beats_queued++;
  endtask

  function automatic logic [31:0] pick_entry();
    logic [31:0] top;
    case (cur_type)
      fncl_pkg::FAT12: top = 32'(fncl_pkg::MASK12);
      fncl_pkg::FAT16: top = 32'h0000_FFFF;
      fncl_pkg::FAT32: top = fncl_pkg::MASK28;
      default:         top = 32'hFFFF_FFFF;
    endcase
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return end_mark();
      2:       return end_mark() - 1;
      3:       return top;
      4:       return 32'd1;
      default: return $urandom & top;
    endcase
  endfunction

  // fill beats that place one entry value, reserved fat32 bits random
  task automatic push_entry(input logic [fncl_pkg::CLUS_W-1:0] clus, input logic [31:0] val);
    logic [63:0] fpos;
    logic [63:0] boff;
    logic [31:0] raw;
    int          nbytes;
    locate(clus, fpos, boff);
    case (cur_type)
      fncl_pkg::FAT12: raw = clus[0] ? {16'h0, val[11:0], 4'($urandom)}
                                     : {16'h0, 4'($urandom), val[11:0]};
      fncl_pkg::FAT32: raw = {4'($urandom), val[27:0]};
      default:         raw = val;
    endcase
    nbytes = (cur_type == fncl_pkg::FAT12 || cur_type == fncl_pkg::FAT16) ? 2 : 4;
    for (int i = 0; i < nbytes; i++)
      push_fill(fncl_pkg::CACHE_AW'(boff + 64'(i)), raw[8*i +: 8], 1'b0, $urandom);
  endtask

  // miss, short load of entries, tag commit, then lookups around it
  task automatic queue_chain();
    logic [fncl_pkg::CLUS_W-1:0] first;
    logic [63:0]                 fpos;
    logic [63:0]                 boff;
    int unsigned                 span;
    int unsigned                 k;
    first = ($urandom_range(0, 1) == 0) ? fncl_pkg::CLUS_W'($urandom_range(0, 5000))
                                        : $urandom;
    locate(first, fpos, boff);
    span = (cur_type == fncl_pkg::FAT12) ? (2 << sector_shift()) : (1 << sector_shift());
    k    = $urandom_range(1, 4);
    if ($urandom_range(0, 3) != 0) push_lookup(first);
    for (int i = 0; i < k; i++) push_entry(first + fncl_pkg::CLUS_W'(i), pick_entry());
    repeat ($urandom_range(0, 3))
      push_fill(fncl_pkg::CACHE_AW'($urandom_range(0, span - 1)), 8'($urandom), 1'b0,
                $urandom);
    push_fill(fncl_pkg::CACHE_AW'($urandom_range(0, span - 1)), 8'($urandom), 1'b1,
              ($urandom_range(0, 9) != 0) ? fncl_pkg::TAG_W'(fpos)
                                          : fncl_pkg::TAG_W'($urandom));
    for (int i = 0; i < k + 2; i++)
      push_lookup(first + fncl_pkg::CLUS_W'($urandom_range(0, k + 1)));
    if ($urandom_range(0, 3) == 0) push_lookup(first - 1);
  endtask

  task automatic queue_noise();
    if ($urandom_range(0, 1) == 0)
      push_lookup(($urandom_range(0, 1) == 0) ? fncl_pkg::CLUS_W'($urandom_range(0, 300))
                                              : $urandom);
    else
      push_fill(fncl_pkg::CACHE_AW'($urandom), 8'($urandom), ($urandom_range(0, 7) == 0),
                ($urandom_range(0, 1) == 0) ? fncl_pkg::TAG_NONE
                                            : fncl_pkg::TAG_W'($urandom));
  endtask

  task automatic cfg_write(input logic [fncl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fncl_pkg::CFG_DAT_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == fncl_pkg::REG_FAT_TYPE || idx == fncl_pkg::REG_SECTOR_LG2)
      q_tag = fncl_pkg::TAG_NONE;
  endtask

  task automatic settle();
    while (host_beats.size() > 0 || in_ch.valid || due_answers.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input fat_answer_t want,
                               input fat_answer_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: exp %0b/%h/%0d/%h/%0b got %0b/%h/%0d/%h/%0b",
               what, want.hit, want.read_sector, want.read_count, want.next_cluster,
               want.end_of_chain, got.hit, got.read_sector, got.read_count,
               got.next_cluster, got.end_of_chain);
  endtask

  // sender: bursts of random length with random gaps
  always @(negedge clk) begin
    host_beat_t b;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (host_beats.size() > 0) begin
        b = host_beats.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= b.mode;
        in_ch.cluster     <= b.cluster;
        in_ch.fill_sector <= b.fill_sector;
        in_ch.fill_offset <= b.fill_offset;
        in_ch.fill_byte   <= b.fill_byte;
        in_ch.fill_last   <= b.fill_last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: rotating ready pattern, swapped now and then
  always @(negedge clk) begin
    if (pat_age == 0) begin
      pat_age = $urandom_range(16, 96);
      case ($urandom_range(0, 3))
        0:       ready_pat = 16'hFFFF;
        1:       ready_pat = 16'h0001;
        2:       ready_pat = 16'($urandom) | 16'h0001;
        default: ready_pat = 16'($urandom) | 16'h8421;
      endcase
    end else begin
      pat_age--;
    end
    pat_pos = (pat_pos + 1) % 16;
    out_ch.ready <= rst_n && ready_pat[pat_pos];
  end

  // monitor, cache image and answer check
  always @(posedge clk) begin
    host_beat_t  b;
    fat_answer_t got;
    fat_answer_t want;
    in_taken = in_ch.valid && in_ch.ready;
    if (!rst_n) begin
      tag_img     = fncl_pkg::TAG_NONE;
      cur_type    = fncl_pkg::FAT12;
      cur_lg2     = 4'(fncl_pkg::SH_MIN);
      cur_base    = '0;
      idle_cycles = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.hit, out_ch.read_sector, out_ch.read_count, out_ch.next_cluster,
               out_ch.end_of_chain};
        if (due_answers.size() == 0) begin
          note_mismatch("unexpected beat", '0, got);
        end else begin
          want = due_answers.pop_front();
          if (got.hit !== want.hit || got.read_sector !== want.read_sector ||
              got.read_count !== want.read_count || got.next_cluster !== want.next_cluster ||
              got.end_of_chain !== want.end_of_chain)
            note_mismatch("field", want, got);
        end
      end
      if (in_taken) begin
        b = {in_ch.mode, in_ch.cluster, in_ch.fill_sector, in_ch.fill_offset,
             in_ch.fill_byte, in_ch.fill_last};
        if (b.mode == MODE_FILL) begin
          cache_img[b.fill_offset] = b.fill_byte;
          if (b.fill_last) tag_img = b.fill_sector;
        end else begin
          due_answers.push_back(answer_lookup(b.cluster));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          fncl_pkg::REG_FAT_TYPE: begin
            cur_type = cfg_ch.data[1:0];
            tag_img  = fncl_pkg::TAG_NONE;
          end
          fncl_pkg::REG_SECTOR_LG2: begin
            cur_lg2 = cfg_ch.data[3:0];
            tag_img = fncl_pkg::TAG_NONE;
          end
          fncl_pkg::REG_FAT_BASE: cur_base = cfg_ch.data[fncl_pkg::SECTOR_W-1:0];
          default: ;
        endcase
      end
      if (in_taken || (out_ch.valid && out_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0] lg2_pick [4];
    int         start;
    lg2_pick          = '{4'd9, 4'd12, 4'd0, 4'd15};
    mismatches        = 0;
    beats_queued      = 0;
    burst_left        = 0;
    gap_left          = 0;
    pat_age           = 0;
    pat_pos           = 0;
    ready_pat         = 16'hFFFF;
    in_taken          = 1'b0;
    q_tag             = fncl_pkg::TAG_NONE;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_LOOKUP;
    in_ch.cluster     = '0;
    in_ch.fill_sector = '0;
    in_ch.fill_offset = '0;
    in_ch.fill_byte   = '0;
    in_ch.fill_last   = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = fncl_pkg::REG_FAT_TYPE;
    cfg_ch.data       = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fat12 at reset settings: misses, tag all ones, straddling entry
    push_lookup(32'd0);
    push_fill(13'd0, 8'h00, 1'b0, 32'd5);
    push_fill(13'd1, 8'hF0, 1'b0, 32'd5);
    push_fill(13'd2, 8'hFF, 1'b0, 32'd5);
    push_fill(13'h1FFF, 8'hA5, 1'b1, fncl_pkg::TAG_NONE);
    push_lookup(32'd1);
    push_fill(13'd3, 8'h5A, 1'b1, 32'd0);
    push_lookup(32'd0);
    push_lookup(32'd1);
    push_lookup(32'd341);
    push_lookup(32'd342);
    push_lookup(32'hFFFF_FFFF);
    settle();
    cfg_write(fncl_pkg::REG_SECTOR_LG2, 48'd9);
    cfg_write(REG_SPARE, rand48());
    push_lookup(32'd0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      cfg_write(fncl_pkg::REG_FAT_TYPE, {46'(rand48()), 2'(p)});
      cfg_write(fncl_pkg::REG_SECTOR_LG2,
                {44'(rand48()), (p < 16) ? lg2_pick[p / 4] : 4'($urandom_range(10, 11))});
      case (p % 3)
        0:       cfg_write(fncl_pkg::REG_FAT_BASE, '0);
        1:       cfg_write(fncl_pkg::REG_FAT_BASE, '1);
        default: cfg_write(fncl_pkg::REG_FAT_BASE, rand48());
      endcase
      if (p % 5 == 3) cfg_write(REG_SPARE, rand48());
      start = beats_queued;
      while (beats_queued - start < PHASE_BEATS) begin
        if ($urandom_range(0, 9) < 7) queue_chain();
        else queue_noise();
      end
      settle();
    end

    settle();
    if (mismatches == 0 && due_answers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/fncl_pkg.sv
hdl/fncl_in_if.sv
hdl/fncl_out_if.sv
hdl/fncl_cfg_if.sv
hdl/fncl_ctrl.sv
hdl/fncl_dp.sv
hdl/fat_next_cluster_lookup_top.sv
verif/fat_next_cluster_lookup_top_tb.sv
